// File: src/assert_macros.svh
// Assertion macros shared by the dust meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/dlpom_pkg.sv
// Shared types and constants of the low pulse occupancy dust meter.
package dlpom_pkg;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam int RATIO_W     = 23;
   localparam int RATIO_FRAC  = 16;
   localparam int CONC_W      = 29;
   localparam int ACC_W       = 78;
   localparam int POS_W       = 77;
   localparam int SCALE_SHIFT = 40;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 56;

   // The reciprocal of one hundred scaled by 2^44 and rounded up is exact below 2^37.
   localparam int RECIP_W     = 38;
   localparam int RECIP_SPLIT = 19;
   localparam int RECIP_SHIFT = 44;
   localparam logic [RECIP_W-1:0]             RECIP_M  = 38'd175921860445;
   localparam logic [RECIP_SPLIT-1:0]         RECIP_LO = RECIP_M[RECIP_SPLIT-1:0];
   localparam logic [RECIP_W-RECIP_SPLIT-1:0] RECIP_HI = RECIP_M[RECIP_W-1:RECIP_SPLIT];

   localparam logic [ACC_W-1:0] POLY_A_OFFSET = ACC_W'(380) << 16;
   localparam logic [ACC_W-1:0] POLY_B_OFFSET = ACC_W'(52000) << 32;
   localparam logic [ACC_W-1:0] POLY_P_OFFSET = ACC_W'(62) << 48;

   localparam logic [RATIO_W-1:0] RATIO_MAX = 23'd6553600;
   localparam logic [CONC_W-1:0]  CONC_MAX  = 29'd285212671;

   typedef struct packed {
      logic start_read;
      logic tick;
      logic div_step;
      logic mul_a_load;
      logic mul_b_load;
      logic mul_step;
      logic div_c_load;
      logic conc_load;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic low_zero;
      logic out_free;
   } dp_status_type;

endpackage

// File: src/dlpom_div.sv
// Restoring divider that produces one quotient bit per cycle in which step is asserted.
module dlpom_div #(
   parameter int DIVIDEND_W = 55,
   parameter int DIVISOR_W  = 32
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [DIVIDEND_W-1:0]         dividend,
   input  logic [DIVISOR_W-1:0]          divisor,
   output logic [dlpom_pkg::RATIO_W-1:0] quotient
);
   import dlpom_pkg::*;

   logic [DIVIDEND_W-1:0] dd_ff, dd_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [RATIO_W-1:0]    quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, dd_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      dd_in  = dd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (load) begin
         dd_in  = dividend;
         dvs_in = divisor;
         rem_in = '0;
         quo_in = '0;
      end else if (step) begin
         dd_in  = {dd_ff[DIVIDEND_W-2:0], 1'b0};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[RATIO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      dd_ff  <= dd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

// File: src/dlpom_dp.sv
// Datapath of the dust meter: counters, ratio divider, serial multiplier and output scaling.
module dlpom_dp #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dlpom_pkg::dp_cmd_type          cmd,
   output dlpom_pkg::dp_status_type       status,
   input  logic                           req_pin_level,
   input  logic                           csr_valid,
   input  logic                           csr_data,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [dlpom_pkg::CONC_W-1:0]   rsp_concentration_q8,
   output logic [dlpom_pkg::RATIO_W-1:0]  rsp_ratio_q16
);
   import dlpom_pkg::*;

   localparam int DIV_W    = COUNT_WIDTH + RATIO_W;
   localparam int X100_W   = COUNT_WIDTH + 7;
   localparam int SCALED_W = POS_W - SCALE_SHIFT;
   localparam int PROD_W   = SCALED_W + RECIP_SPLIT;
   localparam int FULL_W   = SCALED_W + RECIP_W;

   logic                   enable_ff, enable_in;
   logic [COUNT_WIDTH-1:0] low_ff, low_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [COUNT_WIDTH-1:0] total_inc;
   logic [X100_W-1:0]      low_x100;

   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [ACC_W-1:0]       mc_ff, mc_in;
   logic [RATIO_W-1:0]     mr_ff, mr_in;
   logic [RATIO_W-1:0]     ratio_ff, ratio_in;
   logic                   zero_ff, zero_in;
   logic [ACC_W-1:0]       r_ext;
   logic [ACC_W-1:0]       a_val;

   logic [SCALED_W-1:0]    scaled;
   logic [PROD_W-1:0]      prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0]      prod_hi;
   logic [FULL_W-1:0]      prod_sum;
   logic [CONC_W-1:0]      conc_ff, conc_in;

   logic                   out_valid_ff, out_valid_in;
   logic [CONC_W-1:0]      out_conc_ff, out_conc_in;
   logic [RATIO_W-1:0]     out_ratio_ff, out_ratio_in;

   logic [DIV_W-1:0]       div_dividend;
   logic [RATIO_W-1:0]     div_q;

   assign total_inc = (total_ff != '1) ? total_ff + 1'b1 : total_ff;
   assign low_x100  = X100_W'({low_ff, 6'b0}) + X100_W'({low_ff, 5'b0})
                    + X100_W'({low_ff, 2'b0});

   assign r_ext = ACC_W'(div_q);
   assign a_val = (r_ext << 7) - (r_ext << 4) - (r_ext << 1) - POLY_A_OFFSET;

   assign scaled   = acc_ff[POS_W-1:SCALE_SHIFT];
   assign prod_hi  = PROD_W'(scaled) * PROD_W'(RECIP_HI);
   assign prod_sum = (FULL_W'(prod_hi) << RECIP_SPLIT) + FULL_W'(prod_lo_ff);

   assign div_dividend = {low_x100, 16'b0};

   dlpom_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .load     (cmd.start_read),
      .step     (cmd.div_step),
      .dividend (div_dividend),
      .divisor  (total_ff),
      .quotient (div_q)
   );

   always_comb begin
      enable_in    = csr_valid ? csr_data : enable_ff;
      low_in       = low_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      mc_in        = mc_ff;
      mr_in        = mr_ff;
      ratio_in     = ratio_ff;
      zero_in      = zero_ff;
      prod_lo_in   = prod_lo_ff;
      conc_in      = conc_ff;
      out_valid_in = out_valid_ff;
      out_conc_in  = out_conc_ff;
      out_ratio_in = out_ratio_ff;

      if (cmd.start_read) begin
         low_in   = '0;
         total_in = '0;
         ratio_in = '0;
         zero_in  = (low_ff == '0);
      end else if (cmd.tick && enable_ff) begin
         total_in = total_inc;
         if (!req_pin_level && (low_ff < total_inc)) begin
            low_in = low_ff + 1'b1;
         end
      end

      if (cmd.mul_a_load) begin
         ratio_in = div_q;
         mc_in    = a_val;
         mr_in    = div_q;
         acc_in   = POLY_B_OFFSET;
      end else if (cmd.mul_b_load) begin
         mc_in  = acc_ff;
         mr_in  = ratio_ff;
         acc_in = POLY_P_OFFSET;
      end else if (cmd.mul_step) begin
         if (mr_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in = {mc_ff[ACC_W-2:0], 1'b0};
         mr_in = {1'b0, mr_ff[RATIO_W-1:1]};
      end

      if (cmd.div_c_load) begin
         prod_lo_in = PROD_W'(scaled) * PROD_W'(RECIP_LO);
      end
      if (cmd.conc_load) begin
         conc_in = prod_sum[RECIP_SHIFT +: CONC_W];
      end

      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_conc_in  = zero_ff ? '0 : conc_ff;
         out_ratio_in = ratio_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         low_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         low_ff       <= low_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      mc_ff        <= mc_in;
      mr_ff        <= mr_in;
      ratio_ff     <= ratio_in;
      zero_ff      <= zero_in;
      prod_lo_ff   <= prod_lo_in;
      conc_ff      <= conc_in;
      out_conc_ff  <= out_conc_in;
      out_ratio_ff <= out_ratio_in;
   end

   assign status.low_zero = (low_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid           = out_valid_ff;
   assign rsp_concentration_q8 = out_conc_ff;
   assign rsp_ratio_q16        = out_ratio_ff;

endmodule

// File: src/dlpom_ctrl.sv
// Controller state machine that sequences a read through division and polynomial steps.
module dlpom_ctrl #(
   parameter int DIV_STEPS = 55
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tuser,
   output logic                      req_tready,
   input  dlpom_pkg::dp_status_type  status,
   output dlpom_pkg::dp_cmd_type     cmd
);
   import dlpom_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(RATIO_W - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_R,
      S_MUL_A_LD,
      S_MUL_A,
      S_MUL_B_LD,
      S_MUL_B,
      S_DIV_C_LD,
      S_DIV_C,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == CMD_READ) begin
                  cmd.start_read = 1'b1;
                  if (status.low_zero) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_DIV_R;
                     cnt_in   = DIV_LAST;
                  end
               end else begin
                  cmd.tick = 1'b1;
               end
            end
         end
         S_DIV_R: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_MUL_A_LD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_MUL_A_LD: begin
            cmd.mul_a_load = 1'b1;
            cnt_in         = MUL_LAST;
            state_in       = S_MUL_A;
         end
         S_MUL_A: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_MUL_B_LD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_MUL_B_LD: begin
            cmd.mul_b_load = 1'b1;
            cnt_in         = MUL_LAST;
            state_in       = S_MUL_B;
         end
         S_MUL_B: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DIV_C_LD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DIV_C_LD: begin
            cmd.div_c_load = 1'b1;
            state_in       = S_DIV_C;
         end
         S_DIV_C: begin
            cmd.conc_load = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: src/dust_low_pulse_occupancy_meter_top.sv
// Top level of the low pulse occupancy dust meter.
// Ticks are accepted back to back while idle.
// A read result turns valid after the bit-serial ratio divider, two passes of the shift-add
// multiplier and the division by one hundred; with no low ticks it skips these steps. Input
// reopens as the result turns valid, unless an earlier result still waits.
// Synchronous reset clears both counters, the sampling enable and the result valid flag.
`include "assert_macros.svh"

module dust_low_pulse_occupancy_meter_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bit 0: pin_level; bits 7:1 are zero.
   input  logic [dlpom_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Bit 0: cmd.
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits 28:0: concentration_q8; bits 51:29: ratio_q16; bits 55:52 are zero.
   output logic [dlpom_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_data
);
   import dlpom_pkg::*;

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [CONC_W-1:0]  conc;
   logic [RATIO_W-1:0] ratio;

   assign csr_ready = 1'b1;

   dlpom_ctrl #(
      .DIV_STEPS (COUNT_WIDTH + RATIO_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dlpom_dp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_pin_level        (req_tdata[0]),
      .csr_valid            (csr_valid),
      .csr_data             (csr_data),
      .rsp_tready           (rsp_tready),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_concentration_q8 (conc),
      .rsp_ratio_q16        (ratio)
   );

   assign rsp_tdata = {{(RSP_DATA_W - CONC_W - RATIO_W){1'b0}}, ratio, conc};

   `ASSERT_NEXT(a_read_blocks_input, clock, reset, req_tvalid && req_tready && req_tuser == CMD_READ, !req_tready, "input stays open after a read transaction")
   `ASSERT_NEXT(a_tick_no_result, clock, reset, req_tvalid && req_tready && req_tuser == CMD_TICK && !rsp_tvalid, !rsp_tvalid, "tick transaction produced a result")
   `ASSERT_IMPLY(a_ratio_range, clock, reset, rsp_tvalid, rsp_tdata[51:29] <= RATIO_MAX, "ratio above one hundred percent")
   `ASSERT_IMPLY(a_conc_range, clock, reset, rsp_tvalid, rsp_tdata[28:0] <= CONC_MAX, "concentration above curve maximum")

endmodule
